// File: rtl/core/zero_pointer_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver checkers.
`ifndef ZERO_POINTER_FRAME_RECEIVER_MACROS_SVH
`define ZERO_POINTER_FRAME_RECEIVER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ZPFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zpfr assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define ZPFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zpfr assertion failed");

`endif

// File: rtl/core/zpfr_pkg.sv
// Shared types, constants and the CRC-8 step of the frame receiver.
`timescale 1ns / 1ps
package zpfr_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] HdrRespMask  = 8'h80;
  localparam logic [7:0] HdrReadMask  = 8'h20;
  localparam logic [7:0] HdrKindMask  = 8'hC0;
  localparam logic [7:0] HdrAckKind   = 8'h40;
  localparam logic [7:0] HdrChainMask = 8'h0F;
  localparam logic [7:0] HdrFlagMask  = 8'hF0;
  localparam logic [7:0] CrcPoly      = 8'h07;

  typedef enum logic [2:0] {
    SLOT_HEADER = 3'd0,
    SLOT_NODE   = 3'd1,
    SLOT_IDX_HI = 3'd2,
    SLOT_IDX_LO = 3'd3,
    SLOT_VAL_HI = 3'd4,
    SLOT_VAL_LO = 3'd5,
    SLOT_CRC    = 3'd6
  } slot_e;

  typedef struct packed {
    slot_e      slot;
    logic [7:0] data;
  } entry_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/zero_pointer_frame_receiver.sv
// Top level of the zero-pointer frame receiver with SMBus CRC-8 check.
`timescale 1ns / 1ps
// The receiver takes one byte per cycle while the queue has room. A zero byte opens
// a frame, and the seven nonzero bytes after it (header, node, index high and low,
// value high and low, CRC) give exactly one result. Zeros stuffed by the sender are
// restored through the header's zero-pointer chain, and a CRC-8 with polynomial 0x07
// over the header and payload is compared with the CRC byte. A failed check gives a
// result with crc_ok low and all other fields zero. The back end does one chain
// step and one CRC byte update per byte; the result is registered as the CRC byte
// leaves the queue, unless an earlier result still waits. A two-entry queue sits
// between the byte classifier and the decoder, and the result register lets the
// next frame stream in while a result waits.
module zero_pointer_frame_receiver import zpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        crc_ok_o,
  output logic        is_response_o,
  output logic        is_read_o,
  output logic        is_error_o,
  output logic        ack_required_o,
  output logic [7:0]  node_o,
  output logic [15:0] reg_index_o,
  output logic [15:0] data_value_o,
  output logic [15:0] fault_code_o
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  zpfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_byte_i    (rx_byte_i),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  zpfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  zpfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .crc_ok_o       (crc_ok_o),
    .is_response_o  (is_response_o),
    .is_read_o      (is_read_o),
    .is_error_o     (is_error_o),
    .ack_required_o (ack_required_o),
    .node_o         (node_o),
    .reg_index_o    (reg_index_o),
    .data_value_o   (data_value_o),
    .fault_code_o   (fault_code_o)
  );

endmodule

// File: rtl/core/zpfr_front.sv
// Front end: tracks the frame position and forwards frame bytes tagged by slot.
`timescale 1ns / 1ps
module zpfr_front import zpfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output entry_t     push_entry_o
);

  logic [2:0] pos_q, pos_d;
  logic       accept;
  logic       is_mark;

  assign is_mark      = (rx_byte_i == 8'h00);
  assign rx_ready_o   = push_ready_i;
  assign accept       = rx_valid_i && push_ready_i;
  assign push_valid_o = rx_valid_i && !is_mark && (pos_q != 3'd0);

  assign push_entry_o.slot = slot_e'(pos_q - 3'd1);
  assign push_entry_o.data = rx_byte_i;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (is_mark) begin
        pos_d = 3'd1;
      end else if (pos_q != 3'd0) begin
        if (pos_q == (3'(SLOT_CRC) + 3'd1)) begin
          pos_d = 3'd0;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// File: rtl/core/zpfr_queue.sv
// Small queue of tagged frame bytes between the front and back ends.
`timescale 1ns / 1ps
module zpfr_queue import zpfr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  entry_t push_entry_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output entry_t pop_entry_o
);

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: rtl/core/zpfr_back.sv
// Back end: restores stuffed zeros, runs the CRC-8 and registers the decoded result.
`timescale 1ns / 1ps
module zpfr_back import zpfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  entry_t      pop_entry_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        crc_ok_o,
  output logic        is_response_o,
  output logic        is_read_o,
  output logic        is_error_o,
  output logic        ack_required_o,
  output logic [7:0]  node_o,
  output logic [15:0] reg_index_o,
  output logic [15:0] data_value_o,
  output logic [15:0] fault_code_o
);

  logic [7:0] chain_q, chain_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] hdr_q, node_q, idx_hi_q, idx_lo_q, val_hi_q, val_lo_q;
  logic [7:0] chain_dec;
  logic [7:0] restored;
  logic       out_free;
  logic       do_pop;
  logic       load_res;
  logic       ok;
  logic       err;

  logic        res_valid_q;
  logic        crc_ok_q, is_response_q, is_read_q, is_error_q, ack_required_q;
  logic [7:0]  node_res_q;
  logic [15:0] reg_index_q, data_value_q, fault_code_q;

  assign out_free    = !res_valid_q || res_ready_i;
  assign pop_ready_o = (pop_entry_i.slot != SLOT_CRC) || out_free;
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign load_res    = do_pop && (pop_entry_i.slot == SLOT_CRC);

  assign chain_dec = chain_q - 8'd1;
  assign restored  = (chain_dec == 8'd0) ? 8'd0 : pop_entry_i.data;

  always_comb begin
    chain_d = (chain_dec == 8'd0) ? pop_entry_i.data : chain_dec;
    crc_d   = crc8_byte(crc_q, restored);
    if (pop_entry_i.slot == SLOT_HEADER) begin
      chain_d = pop_entry_i.data & HdrChainMask;
      crc_d   = crc8_byte(8'd0, pop_entry_i.data & HdrFlagMask);
    end
  end

  assign ok  = (crc_q == restored);
  assign err = ((hdr_q & HdrKindMask) == HdrKindMask);

  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      chain_q <= chain_d;
      crc_q   <= crc_d;
      case (pop_entry_i.slot)
        SLOT_HEADER: hdr_q    <= pop_entry_i.data & HdrFlagMask;
        SLOT_NODE:   node_q   <= restored;
        SLOT_IDX_HI: idx_hi_q <= restored;
        SLOT_IDX_LO: idx_lo_q <= restored;
        SLOT_VAL_HI: val_hi_q <= restored;
        SLOT_VAL_LO: val_lo_q <= restored;
        default: ;
      endcase
    end
    if (load_res) begin
      crc_ok_q       <= ok;
      is_response_q  <= ok && ((hdr_q & HdrRespMask) != 8'd0);
      is_read_q      <= ok && ((hdr_q & HdrReadMask) != 8'd0);
      is_error_q     <= ok && err;
      ack_required_q <= ok && ((hdr_q & HdrKindMask) == HdrAckKind);
      node_res_q     <= ok ? node_q : 8'd0;
      reg_index_q    <= ok ? {idx_hi_q, idx_lo_q} : 16'd0;
      data_value_q   <= (ok && !err) ? {val_hi_q, val_lo_q} : 16'd0;
      fault_code_q   <= (ok && err) ? {val_hi_q, val_lo_q} : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load_res) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign crc_ok_o       = crc_ok_q;
  assign is_response_o  = is_response_q;
  assign is_read_o      = is_read_q;
  assign is_error_o     = is_error_q;
  assign ack_required_o = ack_required_q;
  assign node_o         = node_res_q;
  assign reg_index_o    = reg_index_q;
  assign data_value_o   = data_value_q;
  assign fault_code_o   = fault_code_q;

endmodule

// File: rtl/core/zpfr_checker.sv
// Port-level checker for the frame receiver and its bind to the top level.
`timescale 1ns / 1ps
`include "zero_pointer_frame_receiver_macros.svh"
module zpfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic        crc_ok_o,
  input logic        is_response_o,
  input logic        is_read_o,
  input logic        is_error_o,
  input logic        ack_required_o,
  input logic [7:0]  node_o,
  input logic [15:0] reg_index_o,
  input logic [15:0] data_value_o,
  input logic [15:0] fault_code_o
);

  logic [60:0] res_bits;
  logic        fields_zero;
  logic        value_split;
  logic        kind_legal;

  assign res_bits = {crc_ok_o, is_response_o, is_read_o, is_error_o, ack_required_o,
                     node_o, reg_index_o, data_value_o, fault_code_o};
  assign fields_zero = !is_response_o && !is_read_o && !is_error_o && !ack_required_o &&
                       (node_o == 8'd0) && (reg_index_o == 16'd0) &&
                       (data_value_o == 16'd0) && (fault_code_o == 16'd0);
  assign value_split = (is_error_o && (data_value_o == 16'd0)) ||
                       (!is_error_o && (fault_code_o == 16'd0));
  assign kind_legal  = !(is_error_o && ack_required_o) && !(is_error_o && !is_response_o) &&
                       !(ack_required_o && is_response_o);

  `ZPFR_ASSERT_NEXT(a_res_held, res_valid_o && !res_ready_i, res_valid_o && $stable(res_bits))
  `ZPFR_ASSERT_SAME(a_bad_crc_zero, res_valid_o && !crc_ok_o, fields_zero)
  `ZPFR_ASSERT_SAME(a_value_split, res_valid_o, value_split)
  `ZPFR_ASSERT_SAME(a_flag_kind, res_valid_o, kind_legal)

endmodule

bind zero_pointer_frame_receiver zpfr_checker u_zpfr_checker (.*);

// File: verif/zero_pointer_frame_receiver_test.sv
// Self-checking testbench for the zero-pointer frame receiver with CRC-8 check.
`timescale 1ns / 1ps
module zero_pointer_frame_receiver_test;
  import zpfr_pkg::*;

  localparam int          HalfPeriod   = 4;
  localparam int          ResetCycles  = 11;
  localparam int          FrameLen     = 7;
  localparam int          PhaseBytes   = 450;
  localparam int          SettleCycles = 16;
  localparam int          StallLimit   = 1000;
  localparam logic [7:0]  StartMark    = 8'h00;

  typedef struct packed {
    logic        crc_ok;
    logic        is_response;
    logic        is_read;
    logic        is_error;
    logic        ack_required;
    logic [7:0]  node;
    logic [15:0] reg_index;
    logic [15:0] data_value;
    logic [15:0] fault_code;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx_byte;
    logic          typed_in;
    frame_result_t result;
  } stim_row_t;

  localparam frame_result_t NoFrame     = '0;
  localparam frame_result_t CrcFailed   = '0;
  localparam frame_result_t ZeroFrameOk = '{crc_ok: 1'b1, default: '0};
  localparam frame_result_t MaxErrorFrame = '{
    crc_ok: 1'b1, is_response: 1'b1, is_read: 1'b0, is_error: 1'b1, ack_required: 1'b0,
    node: 8'hFF, reg_index: 16'hFFFF, data_value: 16'h0000, fault_code: 16'hFFFF};

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  rx_byte_i;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic        res_valid_o;
  logic        res_ready_i;
  logic        crc_ok_o;
  logic        is_response_o;
  logic        is_read_o;
  logic        is_error_o;
  logic        ack_required_o;
  logic [7:0]  node_o;
  logic [15:0] reg_index_o;
  logic [15:0] data_value_o;
  logic [15:0] fault_code_o;

  logic          rx_typed;
  frame_result_t rx_typed_result;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  logic [2:0]      frame_pos;
  logic [6:0][7:0] frame_bytes;
  frame_result_t   expected_results [$];
  stim_row_t       stim_table [27];

  int unsigned bytes_sent;
  int unsigned bytes_accepted;
  int unsigned results_checked;
  int unsigned error_count;
  int unsigned stall_cycles;

  zero_pointer_frame_receiver u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_byte_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .crc_ok_o       (crc_ok_o),
    .is_response_o  (is_response_o),
    .is_read_o      (is_read_o),
    .is_error_o     (is_error_o),
    .ack_required_o (ack_required_o),
    .node_o         (node_o),
    .reg_index_o    (reg_index_o),
    .data_value_o   (data_value_o),
    .fault_code_o   (fault_code_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic frame_result_t decode_frame(input logic [6:0][7:0] f);
    logic [7:0]    chain;
    logic [7:0]    crc;
    logic [15:0]   val;
    frame_result_t r;
    chain = f[0] & HdrChainMask;
    for (int i = 1; i < FrameLen; i++) begin
      chain = chain - 8'd1;
      if (chain == 8'd0) begin
        chain = f[i];
        f[i] = 8'h00;
      end
    end
    f[0] = f[0] & HdrFlagMask;
    crc = 8'h00;
    for (int i = 0; i < FrameLen - 1; i++) begin
      crc = crc_update(crc, f[i]);
    end
    r = '0;
    if (crc == f[FrameLen-1]) begin
      r.crc_ok       = 1'b1;
      r.is_response  = (f[0] & HdrRespMask) != 8'h00;
      r.is_read      = (f[0] & HdrReadMask) != 8'h00;
      r.is_error     = (f[0] & HdrKindMask) == HdrKindMask;
      r.ack_required = (f[0] & HdrKindMask) == HdrAckKind;
      r.node         = f[1];
      r.reg_index    = {f[2], f[3]};
      val            = {f[4], f[5]};
      if (r.is_error) begin
        r.fault_code = val;
      end else begin
        r.data_value = val;
      end
    end
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b, output logic done, output frame_result_t r);
    done = 1'b0;
    r    = '0;
    if (b == StartMark) begin
      frame_pos = 3'd1;
    end else if (frame_pos != 3'd0) begin
      frame_bytes[frame_pos - 3'd1] = b;
      if (frame_pos == FrameLen) begin
        frame_pos = 3'd0;
        done      = 1'b1;
        r         = decode_frame(frame_bytes);
      end else begin
        frame_pos = frame_pos + 3'd1;
      end
    end
  endtask

  function automatic logic [7:0] pick_payload_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 2) return 8'h00;
    if (r == 2) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds a valid frame and replaces its zero bytes by the pointer chain.
  function automatic logic [6:0][7:0] build_frame();
    logic [6:0][7:0] raw;
    logic [6:0][7:0] enc;
    logic [7:0]      crc;
    int              last;
    raw[0] = {4'($urandom_range(0, 15)), 4'h0};
    for (int i = 1; i < FrameLen - 1; i++) begin
      raw[i] = pick_payload_byte();
    end
    crc = 8'h00;
    for (int i = 0; i < FrameLen - 1; i++) begin
      crc = crc_update(crc, raw[i]);
    end
    raw[FrameLen-1] = crc;
    enc  = raw;
    last = 0;
    for (int i = 1; i < FrameLen; i++) begin
      if (raw[i] == 8'h00) begin
        if (last == 0) begin
          enc[0][3:0] = 4'(i);
        end else begin
          enc[last] = 8'(i - last);
        end
        last = i;
      end
    end
    if (last != 0) begin
      enc[last] = 8'($urandom_range(FrameLen - last, 255));
    end else if (raw[0][7:4] == 4'h0 || $urandom_range(0, 4) != 0) begin
      enc[0][3:0] = 4'($urandom_range(FrameLen, 15));
    end
    return enc;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed_in = 1'b0,
                           input frame_result_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_byte_i       <= b;
    rx_valid_i      <= 1'b1;
    rx_typed        <= typed_in;
    rx_typed_result <= want;
    bytes_sent++;
    do @(posedge clk_i); while (!rx_ready_o);
  endtask

  task automatic wait_all_results();
    rx_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    logic          done;
    logic          moved;
    frame_result_t predicted;
    frame_result_t want;
    frame_result_t got;
    if (rst_ni) begin
      moved = 1'b0;
      if (rx_valid_i && rx_ready_o) begin
        moved = 1'b1;
        bytes_accepted++;
        predict_byte(rx_byte_i, done, predicted);
        if (done) begin
          expected_results.push_back(rx_typed ? rx_typed_result : predicted);
        end
      end
      if (res_valid_o && res_ready_i) begin
        moved = 1'b1;
        got = '{crc_ok: crc_ok_o, is_response: is_response_o, is_read: is_read_o,
                is_error: is_error_o, ack_required: ack_required_o, node: node_o,
                reg_index: reg_index_o, data_value: data_value_o, fault_code: fault_code_o};
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with none expected, expected nothing, got %h",
                   $time, got);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
          check_field("is_response", 16'(want.is_response), 16'(got.is_response));
          check_field("is_read", 16'(want.is_read), 16'(got.is_read));
          check_field("is_error", 16'(want.is_error), 16'(got.is_error));
          check_field("ack_required", 16'(want.ack_required), 16'(got.ack_required));
          check_field("node", 16'(want.node), 16'(got.node));
          check_field("reg_index", want.reg_index, got.reg_index);
          check_field("data_value", want.data_value, got.data_value);
          check_field("fault_code", want.fault_code, got.fault_code);
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (stall_cycles < StallLimit);
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [6:0][7:0] enc;
    int unsigned     kind;
    int unsigned     pos;
    int unsigned     phase_end;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    rx_byte_i       = 8'h00;
    rx_valid_i      = 1'b0;
    res_ready_i     = 1'b0;
    rx_typed        = 1'b0;
    rx_typed_result = '0;
    send_idle_pct   = 24;
    recv_stall_pct  = 51;
    frame_pos       = 3'd0;
    frame_bytes     = '0;
    bytes_sent      = 0;
    bytes_accepted  = 0;
    results_checked = 0;
    error_count     = 0;
    stall_cycles    = 0;

    stim_table = '{
      '{8'hFF, 1'b0, NoFrame},
      '{StartMark, 1'b0, NoFrame},
      '{8'h80, 1'b0, NoFrame},
      '{StartMark, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b1, ZeroFrameOk},
      '{StartMark, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h01, 1'b0, NoFrame},
      '{8'h02, 1'b0, NoFrame},
      '{8'hFF, 1'b1, CrcFailed},
      '{StartMark, 1'b0, NoFrame},
      '{8'hC0, 1'b0, NoFrame},
      '{8'hFF, 1'b0, NoFrame},
      '{8'hFF, 1'b0, NoFrame},
      '{8'hFF, 1'b0, NoFrame},
      '{8'hFF, 1'b0, NoFrame},
      '{8'hFF, 1'b0, NoFrame},
      '{8'h7D, 1'b1, MaxErrorFrame}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      send_byte(stim_table[i].rx_byte, stim_table[i].typed_in, stim_table[i].result);
    end

    for (int phase = 0; phase < 3; phase++) begin
      wait_all_results();
      send_idle_pct  <= (phase == 0) ? 24 : (phase == 1) ? 51 : 0;
      recv_stall_pct <= (phase == 0) ? 51 : (phase == 1) ? 24 : 0;
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        kind = $urandom_range(0, 99);
        enc  = build_frame();
        if (kind < 85) begin
          if (kind >= 75) begin
            pos = $urandom_range(0, FrameLen - 1);
            enc[pos] = enc[pos] ^ (8'h01 << $urandom_range(0, 7));
          end
          send_byte(StartMark);
          for (int k = 0; k < FrameLen; k++) begin
            send_byte(enc[k]);
          end
        end else if (kind < 93) begin
          send_byte(StartMark);
          for (int k = 0; k < int'($urandom_range(1, FrameLen - 1)); k++) begin
            send_byte(enc[k]);
          end
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)));
        end
      end
    end

    wait_all_results();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d bytes (%0d taken) as clean, corrupted, cut-short and stray input;",
             bytes_sent, bytes_accepted);
    $display("checked %0d frame results under three patterns of sender and receiver stalls.",
             results_checked);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
